[rtl/core/sliding_window_pixel_mode_background_top_macros.svh]
// Assertion helpers for the background model block.
`ifndef SLIDING_WINDOW_PIXEL_MODE_BACKGROUND_TOP_MACROS_SVH
`define SLIDING_WINDOW_PIXEL_MODE_BACKGROUND_TOP_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SWPMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SWPMB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/swpmb_pkg.sv]
package swpmb_pkg;

  localparam int COLOR_W     = 24;
  localparam int CFG_W       = 10;
  localparam int WIN_CFG_W   = 4;
  localparam int CNT_W       = 5;
  localparam int OUT_CNT_W   = 4;
  localparam int OUT_TDATA_W = 32;
  localparam int REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [COLOR_W-1:0] color;
  } pick_t;

endpackage

[rtl/core/swpmb_mode_sel.sv]
module swpmb_mode_sel #(
  parameter int N = 8
) (
  input  logic [N-1:0][swpmb_pkg::CNT_W-1:0]   kc_i,
  input  logic [N-1:0][swpmb_pkg::COLOR_W-1:0] colors_i,
  output swpmb_pkg::pick_t                     top_o
);
  import swpmb_pkg::*;

  localparam int NP = (N > 1) ? 2 ** $clog2(N) : 1;

  pick_t node [1:2*NP-1];

  // highest count wins, ties go to the smaller color
  function automatic pick_t better(input pick_t a, input pick_t b);
    if (a.count > b.count || (a.count == b.count && a.color <= b.color)) begin
      return a;
    end
    return b;
  endfunction

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      if (i < N) begin
        node[NP+i].count = kc_i[i];
        node[NP+i].color = colors_i[i];
      end else begin
        node[NP+i] = '0;
      end
    end
    for (int i = NP - 1; i >= 1; i--) begin
      node[i] = better(node[2*i], node[2*i+1]);
    end
  end

  assign top_o = node[1];

endmodule

[rtl/core/sliding_window_pixel_mode_background_top.sv]
// Path from input transaction to result on m_axis: memory read, count, pair compare,
//   occurrence count and rescan/writeback stages, then the output register.
// Throughput: one pixel per cycle unless m_axis stalls; a pixel whose location is still in
//   flight waits, as in frames of 4 pixels or fewer or after a position-clearing write.
// Reset (rst_ni low, async): registers to 512/512/8, position and frame count cleared;
//   writes to width, height or window length clear them too. No clearing pass: the
//   frame count marks per-location entries not yet written in the current model.
`include "sliding_window_pixel_mode_background_top_macros.svh"
module sliding_window_pixel_mode_background_top #(
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_ROWS    = 512,
  parameter int MAX_WINDOW  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swpmb_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  logic [swpmb_pkg::CFG_W-1:0]         cfg_wdata_i,
  // pixel input; tdata: pixel_color[23:0]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [swpmb_pkg::COLOR_W-1:0]       s_axis_tdata,
  // result; tdata: background_color[23:0], background_count[27:24], zero pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [swpmb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import swpmb_pkg::*;

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int LOC_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  typedef logic [MAX_WINDOW-1:0][COLOR_W-1:0]   hist_row_t;
  typedef logic [MAX_WINDOW-1:0][MAX_WINDOW-1:0] eq_mat_t;
  typedef logic [MAX_WINDOW-1:0][CNT_W-1:0]     kc_vec_t;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0]     w_q, h_q;
  logic [WIN_CFG_W-1:0] wl_q;
  logic [CFG_W-1:0]     w_c, h_c;
  logic [CNT_W-1:0]     wl_c;
  logic                 cfg_we, cfg_clear;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_clear   = cfg_we && (cfg_index_i == REG_FRAME_WIDTH ||
                                  cfg_index_i == REG_FRAME_HEIGHT ||
                                  cfg_index_i == REG_WINDOW_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= CFG_W'(512);
      h_q  <= CFG_W'(512);
      wl_q <= WIN_CFG_W'(8);
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:   w_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT:  h_q  <= cfg_wdata_i;
        REG_WINDOW_LENGTH: wl_q <= cfg_wdata_i[WIN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate to 1..MAX
  always_comb begin
    w_c = w_q;
    if (w_q == '0) w_c = CFG_W'(1);
    else if (int'(w_q) > MAX_COLUMNS) w_c = CFG_W'(MAX_COLUMNS);
    h_c = h_q;
    if (h_q == '0) h_c = CFG_W'(1);
    else if (int'(h_q) > MAX_ROWS) h_c = CFG_W'(MAX_ROWS);
    wl_c = CNT_W'(wl_q);
    if (wl_q == '0) wl_c = CNT_W'(1);
    else if (int'(wl_q) > MAX_WINDOW) wl_c = CNT_W'(MAX_WINDOW);
  end

  // ---------------- raster position ----------------
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [CNT_W-1:0]  frames_q;
  logic [SLOT_W-1:0] slot_q;
  logic [LOC_W-1:0]  loc_in;
  logic              col_last, row_last;

  assign loc_in   = LOC_W'(int'(row_q) * MAX_COLUMNS + int'(col_q));
  assign col_last = (int'(col_q) + 1 >= int'(w_c));
  assign row_last = (int'(row_q) + 1 >= int'(h_c));

  // ---------------- pipeline control ----------------
  logic adv, acc, hazard;
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic [LOC_W-1:0] s1_loc_q, s2_loc_q, s3_loc_q, s4_loc_q;

  // whole pipe moves together when the output register can take a result
  assign adv    = !out_vld_q || m_axis_tready;
  assign hazard = (s1_vld_q && s1_loc_q == loc_in) || (s2_vld_q && s2_loc_q == loc_in) ||
                  (s3_vld_q && s3_loc_q == loc_in) || (s4_vld_q && s4_loc_q == loc_in);
  assign s_axis_tready = adv && !hazard;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      frames_q <= '0;
      slot_q   <= '0;
    end else if (cfg_clear) begin
      col_q    <= '0;
      row_q    <= '0;
      frames_q <= '0;
      slot_q   <= '0;
    end else if (acc) begin
      if (col_last) begin
        col_q <= '0;
        if (row_last) begin
          row_q <= '0;
          if (frames_q < wl_c) frames_q <= frames_q + CNT_W'(1);
          if (CNT_W'(slot_q) + CNT_W'(1) >= wl_c) slot_q <= '0;
          else slot_q <= slot_q + SLOT_W'(1);
        end else begin
          row_q <= row_q + ROW_W'(1);
        end
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= acc;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q;
    end
  end

  // ---------------- per-location memories ----------------
  hist_row_t hist_mem [DEPTH];
  pick_t     best_mem [DEPTH];
  hist_row_t rd_hist_q;
  pick_t     rd_best_q;
  logic      wr_en;
  hist_row_t s4_row_q;
  pick_t     final_pick;

  assign wr_en = adv && s4_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) hist_mem[s4_loc_q] <= s4_row_q;
    if (adv) rd_hist_q <= hist_mem[loc_in];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) best_mem[s4_loc_q] <= final_pick;
    if (adv) rd_best_q <= best_mem[loc_in];
  end

  // ---------------- stage 1: count new color, update row ----------------
  logic [COLOR_W-1:0] s1_color_q;
  logic [SLOT_W-1:0]  s1_slot_q;
  logic [CNT_W-1:0]   s1_n_q, s1_wl_q;
  logic               s1_full_q, s1_first_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_loc_q   <= loc_in;
      s1_color_q <= s_axis_tdata;
      s1_slot_q  <= slot_q;
      s1_n_q     <= frames_q;
      s1_wl_q    <= wl_c;
      s1_full_q  <= (frames_q >= wl_c);
      s1_first_q <= (frames_q == '0);
    end
  end

  pick_t              best0, best1, best2;
  logic [CNT_W-1:0]   cnt;
  logic [COLOR_W-1:0] dropped;
  hist_row_t          new_row;
  logic               drop_hit;

  always_comb begin
    best0 = s1_first_q ? pick_t'('0) : rd_best_q;   // nothing stored yet this model
    cnt   = CNT_W'(1);
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (CNT_W'(k) < s1_n_q && rd_hist_q[k] == s1_color_q) cnt = cnt + CNT_W'(1);
    end
    best1 = best0;
    if (cnt > best0.count) begin
      best1.count = cnt;
      best1.color = s1_color_q;
    end
    dropped = rd_hist_q[s1_slot_q];
    for (int k = 0; k < MAX_WINDOW; k++) begin
      new_row[k] = (SLOT_W'(k) == s1_slot_q) ? s1_color_q : rd_hist_q[k];
    end
    drop_hit = s1_full_q && (dropped == best1.color);
    best2    = best1;
    if (drop_hit && best1.count != '0) best2.count = best1.count - CNT_W'(1);
  end

  // ---------------- stage 2: pairwise equality ----------------
  hist_row_t        s2_row_q, s3_row_q;
  pick_t            s2_best_q, s3_best_q, s4_best_q;
  logic             s2_hit_q, s3_hit_q, s4_hit_q;
  logic [CNT_W-1:0] s2_wl_q, s3_wl_q;
  eq_mat_t          eq_d, s3_eq_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_loc_q  <= s1_loc_q;
      s2_row_q  <= new_row;
      s2_best_q <= best2;
      s2_hit_q  <= drop_hit;
      s2_wl_q   <= s1_wl_q;
    end
  end

  always_comb begin
    eq_d = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      for (int m = k + 1; m < MAX_WINDOW; m++) begin
        eq_d[k][m] = (CNT_W'(m) < s2_wl_q) && (s2_row_q[k] == s2_row_q[m]);
        eq_d[m][k] = eq_d[k][m];
      end
    end
  end

  // ---------------- stage 3: occurrence count per slot ----------------
  kc_vec_t kc_d, s4_kc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_loc_q  <= s2_loc_q;
      s3_row_q  <= s2_row_q;
      s3_best_q <= s2_best_q;
      s3_hit_q  <= s2_hit_q;
      s3_wl_q   <= s2_wl_q;
      s3_eq_q   <= eq_d;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_WINDOW; k++) begin
      kc_d[k] = '0;
      if (CNT_W'(k) < s3_wl_q) begin
        kc_d[k] = CNT_W'(1);
        for (int m = 0; m < MAX_WINDOW; m++) begin
          if (s3_eq_q[k][m]) kc_d[k] = kc_d[k] + CNT_W'(1);
        end
      end
    end
  end

  // ---------------- stage 4: rescan pick, writeback ----------------
  pick_t top;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_loc_q  <= s3_loc_q;
      s4_row_q  <= s3_row_q;
      s4_best_q <= s3_best_q;
      s4_hit_q  <= s3_hit_q;
      s4_kc_q   <= kc_d;
    end
  end

  swpmb_mode_sel #(
    .N (MAX_WINDOW)
  ) u_mode_sel (
    .kc_i     (s4_kc_q),
    .colors_i (s4_row_q),
    .top_o    (top)
  );

  // rescan only replaces the best when the dropped color was the best
  assign final_pick = (s4_hit_q && top.count > s4_best_q.count) ? top : s4_best_q;

  // ---------------- output register ----------------
  pick_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= final_pick;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.count[OUT_CNT_W-1:0], out_q.color});

  // ---------------- assertions ----------------
  `SWPMB_ASSERT(a_no_rw_collision, acc |-> !(wr_en && s4_loc_q == loc_in), "read of a location being written")
  `SWPMB_ASSERT(a_count_nonzero, m_axis_tvalid |-> (out_q.count != '0), "background count is zero")
  `SWPMB_ASSERT_ALWAYS(a_frames_bounded, frames_q <= wl_c || $past(cfg_clear) || !rst_ni, "frame count beyond window")

endmodule
